### src/epd_pkg.sv
// Shared types, codes and constants of the escaped packet deframer.
package epd_pkg;

  localparam logic [7:0] SYNC_DEFAULT   = 8'hE0;
  localparam logic [7:0] ESCAPE_DEFAULT = 8'hD0;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_END_GOOD = 2'd1;
  localparam logic [1:0] KIND_END_BAD  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] value;
    logic       escaped;
  } entry_t;

endpackage

### src/escaped_packet_deframer.sv
// Top level of the escaped packet deframer: front end, queue and frame engine.
//
// Channel   Direction  Transfer when      Payload
// in_       input      in_valid&in_ready  in_rx_byte
// out_      output     out_valid&out_ready out_frame_address, out_payload_byte,
//                                          out_item_kind, out_frame_last
//
// One byte is accepted per cycle while in_ready is high; a result is loaded into the
// output register at the edge its byte leaves the two-entry queue.
// Reset is synchronous and clears the escape flag, the queue and the frame state.
// When the output register is held, the queue absorbs up to two more bytes before
// in_ready drops; bytes that give no result drain from the queue regardless.
module escaped_packet_deframer #(
  parameter logic [7:0] SYNC_VALUE   = epd_pkg::SYNC_DEFAULT,
  parameter logic [7:0] ESCAPE_VALUE = epd_pkg::ESCAPE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_address,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_item_kind,
  output logic       out_frame_last
);
  import epd_pkg::*;

  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   head_valid;
  entry_t head_entry;

  epd_front #(
    .ESCAPE_VALUE(ESCAPE_VALUE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  epd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  epd_back #(
    .SYNC_VALUE(SYNC_VALUE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_address(out_frame_address),
    .out_payload_byte (out_payload_byte),
    .out_item_kind    (out_item_kind),
    .out_frame_last   (out_frame_last)
  );

endmodule

### src/epd_front.sv
// Front end: accepts raw bytes, removes escapes and queues decoded bytes.
module epd_front #(
  parameter logic [7:0] ESCAPE_VALUE = epd_pkg::ESCAPE_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  input  logic            q_full,
  output logic            q_push,
  output epd_pkg::entry_t q_entry
);
  import epd_pkg::*;

  logic esc_pend_r;
  logic esc_pend_nxt;
  logic accept;
  logic is_escape;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_escape = !esc_pend_r && (in_rx_byte == ESCAPE_VALUE);

  always_comb begin
    esc_pend_nxt    = esc_pend_r;
    q_push          = 1'b0;
    q_entry.escaped = esc_pend_r;
    q_entry.value   = esc_pend_r ? in_rx_byte + 8'd1 : in_rx_byte;
    if (accept) begin
      if (is_escape) begin
        esc_pend_nxt = 1'b1;
      end else begin
        esc_pend_nxt = 1'b0;
        q_push       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r <= 1'b0;
    end else begin
      esc_pend_r <= esc_pend_nxt;
    end
  end

endmodule

### src/epd_queue.sv
// Short queue of decoded bytes between the front and the frame engine.
module epd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  epd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output epd_pkg::entry_t head_entry
);
  import epd_pkg::*;

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

### src/epd_back.sv
// Frame engine: tracks frame phase and checksum and drives the result register.
module epd_back #(
  parameter logic [7:0] SYNC_VALUE = epd_pkg::SYNC_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  epd_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_frame_address,
  output logic [7:0]      out_payload_byte,
  output logic [1:0]      out_item_kind,
  output logic            out_frame_last
);
  import epd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       ovalid_r;
  logic [7:0] oaddr_r, odata_r;
  logic [1:0] okind_r;
  logic       olast_r;

  logic       emit;
  logic [7:0] emit_data;
  logic [1:0] emit_kind;
  logic       emit_last;
  logic       can_load;
  logic [7:0] value;
  logic [7:0] sum_add;
  logic [7:0] rem_dec;

  assign value    = head_entry.value;
  assign sum_add  = sum_r + value;
  assign rem_dec  = rem_r - 8'd1;
  assign can_load = !ovalid_r || out_ready;

  always_comb begin
    unique case (phase_r)
      PH_ADDR:  phase_nxt = PH_LEN;
      PH_LEN:   phase_nxt = (value == 8'd1) ? PH_CHECK : PH_DATA;
      PH_DATA:  phase_nxt = (rem_dec == 8'd0) ? PH_CHECK : PH_DATA;
      PH_CHECK: phase_nxt = PH_HUNT;
      default: begin
        phase_nxt = (!head_entry.escaped && value == SYNC_VALUE) ? PH_ADDR : PH_HUNT;
      end
    endcase
  end

  always_comb begin
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    emit      = 1'b0;
    emit_data = value;
    emit_kind = KIND_PAYLOAD;
    emit_last = 1'b0;
    unique case (phase_r)
      PH_ADDR: begin
        addr_nxt = value;
        sum_nxt  = value;
      end
      PH_LEN: begin
        sum_nxt = sum_add;
        rem_nxt = value - 8'd1;
      end
      PH_DATA: begin
        sum_nxt = sum_add;
        rem_nxt = rem_dec;
        emit    = 1'b1;
      end
      PH_CHECK: begin
        emit      = 1'b1;
        emit_data = 8'd0;
        emit_kind = (value == sum_r) ? KIND_END_GOOD : KIND_END_BAD;
        emit_last = 1'b1;
      end
      default: begin
        if (!head_entry.escaped && value == SYNC_VALUE) begin
          sum_nxt = 8'd0;
          rem_nxt = 8'd0;
        end
      end
    endcase
  end

  assign pop = head_valid && (!emit || can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      addr_r   <= 8'd0;
      rem_r    <= 8'd0;
      sum_r    <= 8'd0;
      ovalid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        addr_r  <= addr_nxt;
        rem_r   <= rem_nxt;
        sum_r   <= sum_nxt;
      end
      if (pop && emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      oaddr_r <= addr_r;
      odata_r <= emit_data;
      okind_r <= emit_kind;
      olast_r <= emit_last;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_frame_address = oaddr_r;
  assign out_payload_byte  = odata_r;
  assign out_item_kind     = okind_r;
  assign out_frame_last    = olast_r;

endmodule
